[hw/rtl/clrfs_pkg.sv]
package clrfs_pkg;

  // ring geometry (slot count is a power of two)
  localparam int unsigned FRAME_SLOTS   = 2048;
  localparam int unsigned SLOT_W        = $clog2(FRAME_SLOTS);
  localparam int unsigned PAYLOAD_WORDS = 20;
  localparam int unsigned RING_DEPTH    = FRAME_SLOTS * PAYLOAD_WORDS;
  localparam int unsigned RING_AW       = $clog2(RING_DEPTH);
  localparam int unsigned STAGE_AW      = $clog2(PAYLOAD_WORDS);

  // datagram and packet sizes
  localparam int unsigned FRAME_BYTES = 164;
  localparam int unsigned SEQ_BYTES   = 4;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned LEN_MAX     = 2047;
  localparam logic [15:0] LONG_PKT    = 16'd323;
  localparam logic [15:0] SHORT_PKT   = 16'd162;

  // output word counter
  localparam int unsigned IDX_W = 6;
  localparam logic [IDX_W-1:0] IDX_PAYLOAD_END = IDX_W'(PAYLOAD_WORDS);
  localparam logic [IDX_W-1:0] IDX_LAST_NONE   = IDX_W'(PAYLOAD_WORDS - 1);
  localparam logic [IDX_W-1:0] IDX_LAST_SHORT  = IDX_W'(PAYLOAD_WORDS);
  localparam logic [IDX_W-1:0] IDX_LAST_LONG   = IDX_W'(2 * PAYLOAD_WORDS);

  // byte counts of output words
  localparam logic [3:0] BYTES_FULL       = 4'd8;
  localparam logic [3:0] BYTES_SHORT_TAIL = 4'd2;
  localparam logic [3:0] BYTES_LONG_TAIL  = 4'd3;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CREDIT_PER_FRAME    = 2'd0,
    CFG_CREDIT_CAP          = 2'd1,
    CFG_REDUNDANCY_DISTANCE = 2'd2
  } cfg_index_e;

  localparam logic [15:0] CREDIT_PER_FRAME_RST = 16'd310;
  localparam logic [15:0] CREDIT_CAP_RST       = 16'd1000;
  localparam logic [7:0]  DISTANCE_RST         = 8'd2;

  typedef enum logic [2:0] {
    TX_IDLE,
    TX_CREDIT,
    TX_DECIDE,
    TX_READ,
    TX_EMIT
  } tx_state_e;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_SHORT,
    MODE_LONG
  } mode_e;

  typedef struct packed {
    logic [63:0] in_word;
    logic [3:0]  in_bytes;
    logic        in_last;
  } in_t;

  typedef struct packed {
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        out_last;
  } out_t;

  typedef struct packed {
    logic [15:0] credit_per_frame;
    logic [15:0] credit_cap;
    logic [7:0]  redundancy_distance;
  } cfg_t;

  typedef struct packed {
    logic        done;
    logic [31:0] seq;
  } frame_t;

  typedef struct packed {
    logic                re;
    logic [STAGE_AW-1:0] addr;
  } stage_rd_t;

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    logic [63:0]        wdata;
    logic               re;
    logic [RING_AW-1:0] raddr;
  } ring_req_t;

endpackage

[hw/rtl/credit_limited_redundant_frame_sender.sv]
// start: a frame's closing beat starts the sequencer; its credit, decide, read and emit
//   states come before the first packet beat. throughput: one input beat a cycle
//   between frames; a frame then holds the input for a credit and a decide step, then
//   a read and an emit step per word (stage or ring read, then output)
// reset: asynchronous, active low; the frame ring is then cleared one word a cycle,
//   during which no input beat is taken (configuration writes still are)
module credit_limited_redundant_frame_sender (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  clrfs_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output clrfs_pkg::out_t out_data_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [15:0]     cfg_wdata_i
);

  clrfs_pkg::cfg_t      cfg_q;
  clrfs_pkg::frame_t    frame;
  clrfs_pkg::stage_rd_t stage_rd;
  clrfs_pkg::ring_req_t ring_req;
  logic [63:0] stage_data;
  logic [63:0] ring_data;
  logic        ring_busy;
  logic        tx_idle;
  logic        in_accept;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.credit_per_frame    <= clrfs_pkg::CREDIT_PER_FRAME_RST;
      cfg_q.credit_cap          <= clrfs_pkg::CREDIT_CAP_RST;
      cfg_q.redundancy_distance <= clrfs_pkg::DISTANCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        clrfs_pkg::CFG_CREDIT_PER_FRAME:    cfg_q.credit_per_frame    <= cfg_wdata_i;
        clrfs_pkg::CFG_CREDIT_CAP:          cfg_q.credit_cap          <= cfg_wdata_i;
        clrfs_pkg::CFG_REDUNDANCY_DISTANCE: cfg_q.redundancy_distance <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // input beats only while the ring is clear and no frame is in flight
  assign in_ready_o = !ring_busy && tx_idle;
  assign in_accept  = in_valid_i && in_ready_o;

  clrfs_rx u_rx (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .in_data_i (in_data_i),
    .rd_i      (stage_rd),
    .rd_data_o (stage_data),
    .frame_o   (frame)
  );

  clrfs_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .rd_data_o (ring_data),
    .busy_o    (ring_busy)
  );

  clrfs_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .frame_i      (frame),
    .stage_rd_o   (stage_rd),
    .stage_data_i (stage_data),
    .ring_req_o   (ring_req),
    .ring_data_i  (ring_data),
    .idle_o       (tx_idle),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // a completed frame hands over to the sequencer
  a_frame_starts_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.done |=> !tx_idle)
    else $error("frame end did not start the sequencer");

  // the sequencer never writes the ring during the clearing pass
  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_busy |-> !ring_req.we)
    else $error("ring written during clearing pass");

  // no packet beat before the ring is clear
  a_no_output_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_busy |-> !out_valid_o)
    else $error("packet beat during clearing pass");

  // only a closing beat is short, and only by the packet's tail size
  a_beat_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.out_last ?
      (out_data_o.out_bytes == clrfs_pkg::BYTES_SHORT_TAIL ||
       out_data_o.out_bytes == clrfs_pkg::BYTES_LONG_TAIL) :
      (out_data_o.out_bytes == clrfs_pkg::BYTES_FULL)))
    else $error("packet beat with unexpected byte count");

endmodule

[hw/rtl/clrfs_rx.sv]
module clrfs_rx (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  clrfs_pkg::in_t        in_data_i,
  input  clrfs_pkg::stage_rd_t  rd_i,
  output logic [63:0]           rd_data_o,
  output clrfs_pkg::frame_t     frame_o
);

  logic [clrfs_pkg::LEN_W-1:0] len_q, len_d;
  logic [31:0] seq_q, seq_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] stage_mem [clrfs_pkg::PAYLOAD_WORDS];
  logic [63:0] rd_q;

  logic [63:0] merged;
  logic [63:0] nacc;
  logic        complete;
  logic [clrfs_pkg::STAGE_AW-1:0] cur_word;
  logic [clrfs_pkg::LEN_W-1:0] new_len;

  // byte placement for one input beat
  always_comb begin
    logic [3:0]  n;
    logic [10:0] lenm4;
    logic [11:0] pos;
    logic [11:0] q;
    logic [11:0] sum;
    logic        vb;
    logic [7:0]  b;
    n = (in_data_i.in_bytes > 4'd8) ? 4'd8 : in_data_i.in_bytes;
    lenm4 = len_q - 11'd4;
    cur_word = (len_q < 11'(clrfs_pkg::SEQ_BYTES)) ? '0 : lenm4[7:3];
    merged = acc_q;
    nacc = acc_q;
    complete = 1'b0;
    seq_d = seq_q;
    for (int k = 0; k < 8; k++) begin
      pos = {1'b0, len_q} + 12'(k);
      q = pos - 12'(clrfs_pkg::SEQ_BYTES);
      vb = (4'(k) < n) && (pos < 12'(clrfs_pkg::FRAME_BYTES));
      b = in_data_i.in_word[63 - 8*k -: 8];
      if (vb && pos < 12'(clrfs_pkg::SEQ_BYTES)) begin
        seq_d[5'd31 - {pos[1:0], 3'b000} -: 8] = b;
      end else if (vb) begin
        if (q[7:3] == cur_word) begin
          merged[6'd63 - {q[2:0], 3'b000} -: 8] = b;
          if (q[2:0] == 3'd7) begin
            complete = 1'b1;
          end
        end else begin
          nacc[6'd63 - {q[2:0], 3'b000} -: 8] = b;
        end
      end
    end
    sum = {1'b0, len_q} + 12'(n);
    new_len = (sum > 12'(clrfs_pkg::LEN_MAX)) ? clrfs_pkg::LEN_W'(clrfs_pkg::LEN_MAX)
                                               : sum[clrfs_pkg::LEN_W-1:0];
    acc_d = complete ? nacc : merged;
    len_d = in_data_i.in_last ? '0 : new_len;
  end

  // length counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (accept_i) begin
      len_q <= len_d;
    end
  end

  // sequence and partial payload word
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      seq_q <= seq_d;
      acc_q <= acc_d;
    end
  end

  // staging memory for the payload words
  always_ff @(posedge clk_i) begin
    if (accept_i && complete) begin
      stage_mem[cur_word] <= merged;
    end
    if (rd_i.re) begin
      rd_q <= stage_mem[rd_i.addr];
    end
  end

  assign rd_data_o = rd_q;
  assign frame_o.done = accept_i && in_data_i.in_last &&
                        (new_len == clrfs_pkg::LEN_W'(clrfs_pkg::FRAME_BYTES));
  assign frame_o.seq = seq_q;

endmodule

[hw/rtl/clrfs_ring.sv]
module clrfs_ring (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clrfs_pkg::ring_req_t  req_i,
  output logic [63:0]           rd_data_o,
  output logic                  busy_o
);

  localparam logic [clrfs_pkg::RING_AW-1:0] ClrLast =
    clrfs_pkg::RING_AW'(clrfs_pkg::RING_DEPTH - 1);

  logic [63:0] mem [clrfs_pkg::RING_DEPTH];
  logic [63:0] rd_q;
  logic        clr_q;
  logic [clrfs_pkg::RING_AW-1:0] clr_addr_q;

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == ClrLast) begin
        clr_q <= 1'b0;
      end
    end
  end

  // ring storage
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = clr_q;

endmodule

[hw/rtl/clrfs_tx.sv]
module clrfs_tx (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clrfs_pkg::cfg_t       cfg_i,
  input  clrfs_pkg::frame_t     frame_i,
  output clrfs_pkg::stage_rd_t  stage_rd_o,
  input  logic [63:0]           stage_data_i,
  output clrfs_pkg::ring_req_t  ring_req_o,
  input  logic [63:0]           ring_data_i,
  output logic                  idle_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output clrfs_pkg::out_t       out_data_o
);

  clrfs_pkg::tx_state_e state_q, state_d;
  clrfs_pkg::mode_e     mode_q, mode_d;
  logic [15:0] credit_q, credit_d;
  logic [clrfs_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [63:0] prev_q, prev_d;
  logic [clrfs_pkg::RING_AW-1:0] slot_base_q, slot_base_d;
  logic [clrfs_pkg::RING_AW-1:0] back_base_q, back_base_d;
  logic [clrfs_pkg::SLOT_W-1:0]  bslot_q, bslot_d;
  logic seq_ge_q, seq_ge_d;
  logic out_valid_q, out_valid_d;
  clrfs_pkg::out_t out_q, out_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clrfs_pkg::TX_IDLE;
      mode_q      <= clrfs_pkg::MODE_NONE;
      credit_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      credit_q    <= credit_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prev_q      <= prev_d;
    slot_base_q <= slot_base_d;
    back_base_q <= back_base_d;
    bslot_q     <= bslot_d;
    seq_ge_q    <= seq_ge_d;
    out_q       <= out_d;
  end

  // sequencer
  always_comb begin
    logic [16:0] sum;
    logic [32:0] diff;
    logic [63:0] src;
    logic        need_out;
    logic        go;
    logic [clrfs_pkg::IDX_W-1:0] last_idx;
    state_d     = state_q;
    mode_d      = mode_q;
    credit_d    = credit_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    slot_base_d = slot_base_q;
    back_base_d = back_base_q;
    bslot_d     = bslot_q;
    seq_ge_d    = seq_ge_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    stage_rd_o  = '0;
    ring_req_o  = '0;
    sum  = {1'b0, credit_q} + {1'b0, cfg_i.credit_per_frame};
    diff = {1'b0, frame_i.seq} - {25'b0, cfg_i.redundancy_distance};
    src  = (idx_q < clrfs_pkg::IDX_PAYLOAD_END) ? stage_data_i : ring_data_i;
    need_out = (mode_q != clrfs_pkg::MODE_NONE);
    go = !need_out || !out_valid_q || out_ready_i;
    case (mode_q)
      clrfs_pkg::MODE_LONG:  last_idx = clrfs_pkg::IDX_LAST_LONG;
      clrfs_pkg::MODE_SHORT: last_idx = clrfs_pkg::IDX_LAST_SHORT;
      default:               last_idx = clrfs_pkg::IDX_LAST_NONE;
    endcase

    // output beat taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      clrfs_pkg::TX_IDLE: begin
        if (frame_i.done) begin
          state_d = clrfs_pkg::TX_CREDIT;
        end
      end
      clrfs_pkg::TX_CREDIT: begin
        credit_d = (sum > {1'b0, cfg_i.credit_cap}) ? cfg_i.credit_cap : sum[15:0];
        slot_base_d = clrfs_pkg::RING_AW'(frame_i.seq[clrfs_pkg::SLOT_W-1:0]) *
                      clrfs_pkg::RING_AW'(clrfs_pkg::PAYLOAD_WORDS);
        seq_ge_d = !diff[32];
        bslot_d  = diff[clrfs_pkg::SLOT_W-1:0];
        state_d  = clrfs_pkg::TX_DECIDE;
      end
      clrfs_pkg::TX_DECIDE: begin
        back_base_d = clrfs_pkg::RING_AW'(bslot_q) *
                      clrfs_pkg::RING_AW'(clrfs_pkg::PAYLOAD_WORDS);
        if (credit_q >= clrfs_pkg::LONG_PKT && seq_ge_q) begin
          mode_d   = clrfs_pkg::MODE_LONG;
          credit_d = credit_q - clrfs_pkg::LONG_PKT;
        end else if (credit_q >= clrfs_pkg::SHORT_PKT) begin
          mode_d   = clrfs_pkg::MODE_SHORT;
          credit_d = credit_q - clrfs_pkg::SHORT_PKT;
        end else begin
          mode_d = clrfs_pkg::MODE_NONE;
        end
        idx_d   = '0;
        state_d = clrfs_pkg::TX_READ;
      end
      clrfs_pkg::TX_READ: begin
        // fetch the source word of this output beat
        if (idx_q < clrfs_pkg::IDX_PAYLOAD_END) begin
          stage_rd_o.re   = 1'b1;
          stage_rd_o.addr = idx_q[clrfs_pkg::STAGE_AW-1:0];
        end else if (mode_q == clrfs_pkg::MODE_LONG && idx_q < clrfs_pkg::IDX_LAST_LONG) begin
          ring_req_o.re    = 1'b1;
          ring_req_o.raddr = back_base_q +
                             clrfs_pkg::RING_AW'(idx_q - clrfs_pkg::IDX_PAYLOAD_END);
        end
        state_d = clrfs_pkg::TX_EMIT;
      end
      clrfs_pkg::TX_EMIT: begin
        if (go) begin
          // store the payload word in its ring slot
          if (idx_q < clrfs_pkg::IDX_PAYLOAD_END) begin
            ring_req_o.we    = 1'b1;
            ring_req_o.waddr = slot_base_q + clrfs_pkg::RING_AW'(idx_q);
            ring_req_o.wdata = src;
          end
          // build the packet beat
          if (need_out) begin
            out_valid_d        = 1'b1;
            out_d.out_bytes    = clrfs_pkg::BYTES_FULL;
            out_d.out_last     = 1'b0;
            if (idx_q == '0) begin
              out_d.out_word = {frame_i.seq[15:0], src[63:16]};
            end else if (idx_q < clrfs_pkg::IDX_PAYLOAD_END) begin
              out_d.out_word = {prev_q[15:0], src[63:16]};
            end else if (mode_q == clrfs_pkg::MODE_SHORT) begin
              out_d.out_word  = {prev_q[15:0], 48'b0};
              out_d.out_bytes = clrfs_pkg::BYTES_SHORT_TAIL;
              out_d.out_last  = 1'b1;
            end else if (idx_q == clrfs_pkg::IDX_PAYLOAD_END) begin
              out_d.out_word = {prev_q[15:0], cfg_i.redundancy_distance, src[63:24]};
            end else if (idx_q < clrfs_pkg::IDX_LAST_LONG) begin
              out_d.out_word = {prev_q[23:0], src[63:24]};
            end else begin
              out_d.out_word  = {prev_q[23:0], 40'b0};
              out_d.out_bytes = clrfs_pkg::BYTES_LONG_TAIL;
              out_d.out_last  = 1'b1;
            end
          end
          prev_d = src;
          if (idx_q == last_idx) begin
            state_d = clrfs_pkg::TX_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = clrfs_pkg::TX_READ;
          end
        end
      end
      default: begin
        state_d = clrfs_pkg::TX_IDLE;
      end
    endcase
  end

  assign idle_o      = (state_q == clrfs_pkg::TX_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sim/credit_limited_redundant_frame_sender_tb.sv]
module credit_limited_redundant_frame_sender_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LONG_LEN        = int'(clrfs_pkg::LONG_PKT);
  localparam int unsigned SHORT_LEN       = int'(clrfs_pkg::SHORT_PKT);
  localparam int unsigned PAYLOAD_LEN     = 8 * clrfs_pkg::PAYLOAD_WORDS;
  localparam int unsigned BEATS_PER_PHASE = 40;
  localparam int unsigned SETTLE_CYCLES   = 150;
  localparam int unsigned HOLD_CYCLES     = 2500;
  localparam int          RUN_LIMIT       = 600000;
  localparam int          PROBE_ROWS      = 25;

  // index past the register list, writes to it are dropped
  localparam logic [1:0] CFG_INDEX_SPARE = 2'd3;

  // directed beats, want = packet beats released by this beat
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  cnt;
    logic        last;
    int          want;
  } probe_row_t;

  localparam probe_row_t PROBES [PROBE_ROWS] = '{
    // empty datagram, then two runts
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  1'b1, 0},
    '{64'h0000_0000_0000_0000, 4'd15, 1'b0, 0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd9,  1'b1, 0},
    '{64'h0123_4567_89AB_CDEF, 4'd3,  1'b1, 0},
    // full frame, all-ones sequence
    '{64'hFFFF_FFFF_0000_0000, 4'd8,  1'b0, 0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b0, 0},
    '{64'h0000_0000_0000_0000, 4'd12, 1'b0, 0},
    '{64'h8000_0000_0000_0001, 4'd8,  1'b0, 0},
    '{64'h7FFF_FFFF_FFFF_FFFE, 4'd8,  1'b0, 0},
    '{64'hA5A5_A5A5_A5A5_A5A5, 4'd10, 1'b0, 0},
    '{64'h5A5A_5A5A_5A5A_5A5A, 4'd8,  1'b0, 0},
    '{64'h0123_4567_89AB_CDEF, 4'd8,  1'b0, 0},
    '{64'hFEDC_BA98_7654_3210, 4'd8,  1'b0, 0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 0},
    '{64'h0101_0101_0101_0101, 4'd8,  1'b0, 0},
    '{64'h8080_8080_8080_8080, 4'd8,  1'b0, 0},
    '{64'hC3C3_C3C3_C3C3_C3C3, 4'd8,  1'b0, 0},
    '{64'h3C3C_3C3C_3C3C_3C3C, 4'd8,  1'b0, 0},
    '{64'hF0F0_F0F0_F0F0_F0F0, 4'd8,  1'b0, 0},
    '{64'h0F0F_0F0F_0F0F_0F0F, 4'd8,  1'b0, 0},
    '{64'hCCCC_CCCC_CCCC_CCCC, 4'd8,  1'b0, 0},
    '{64'h3333_3333_3333_3333, 4'd8,  1'b0, 0},
    '{64'h9999_9999_9999_9999, 4'd8,  1'b0, 0},
    '{64'h6666_6666_6666_6666, 4'd8,  1'b0, 0},
    // closing beat: reset credit only covers a short packet
    '{64'hE1E2_E3E4_F5F6_F7F8, 4'd4,  1'b1, 21}
  };

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  clrfs_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready;
  clrfs_pkg::out_t out_data;
  logic            cfg_we;
  logic [1:0]      cfg_index;
  logic [15:0]     cfg_wdata;

  // mirror of the block state
  logic [15:0] cfg_cpf  = clrfs_pkg::CREDIT_PER_FRAME_RST;
  logic [15:0] cfg_cap  = clrfs_pkg::CREDIT_CAP_RST;
  logic [7:0]  cfg_dist = clrfs_pkg::DISTANCE_RST;
  logic [15:0] credit   = '0;
  int unsigned rx_len   = 0;
  logic [7:0]  rx_bytes [clrfs_pkg::FRAME_BYTES];
  bit   [63:0] ring_copy [clrfs_pkg::RING_DEPTH];

  clrfs_pkg::out_t packet_beats_due [$];
  clrfs_pkg::out_t due_beat;
  int          errors        = 0;
  int          cycles        = 0;
  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned beats_pushed  = 0;
  logic [31:0] next_seq      = '0;

  credit_limited_redundant_frame_sender u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // credit update, ring store and packet assembly for one complete frame
  task automatic build_packet(output int released);
    logic [7:0]  pkt [LONG_LEN];
    logic [16:0] sum;
    logic [31:0] seq;
    logic [31:0] back;
    logic [63:0] w;
    int unsigned slot, len, pos, n, i, k;
    sum = credit + cfg_cpf;
    if (sum > cfg_cap) sum = cfg_cap;
    credit = sum[15:0];
    seq  = {rx_bytes[0], rx_bytes[1], rx_bytes[2], rx_bytes[3]};
    slot = seq % clrfs_pkg::FRAME_SLOTS;
    for (i = 0; i < clrfs_pkg::PAYLOAD_WORDS; i++) begin
      for (k = 0; k < 8; k++) w[63 - 8*k -: 8] = rx_bytes[clrfs_pkg::SEQ_BYTES + 8*i + k];
      ring_copy[slot * clrfs_pkg::PAYLOAD_WORDS + i] = w;
    end
    pkt[0] = seq[15:8];
    pkt[1] = seq[7:0];
    for (i = 0; i < PAYLOAD_LEN; i++) pkt[2 + i] = rx_bytes[clrfs_pkg::SEQ_BYTES + i];
    len = 0;
    if (credit >= clrfs_pkg::LONG_PKT && seq >= cfg_dist) begin
      // long packet carries an older payload from the ring
      back = (seq - cfg_dist) % clrfs_pkg::FRAME_SLOTS;
      pkt[SHORT_LEN] = cfg_dist;
      for (i = 0; i < clrfs_pkg::PAYLOAD_WORDS; i++) begin
        w = ring_copy[back * clrfs_pkg::PAYLOAD_WORDS + i];
        for (k = 0; k < 8; k++) pkt[SHORT_LEN + 1 + 8*i + k] = w[63 - 8*k -: 8];
      end
      credit = credit - clrfs_pkg::LONG_PKT;
      len = LONG_LEN;
    end else if (credit >= clrfs_pkg::SHORT_PKT) begin
      credit = credit - clrfs_pkg::SHORT_PKT;
      len = SHORT_LEN;
    end
    // cut into beats, unused tail bytes zero
    pos = 0;
    released = 0;
    while (pos < len) begin
      n = (len - pos > 8) ? 8 : len - pos;
      w = '0;
      for (k = 0; k < n; k++) w[63 - 8*k -: 8] = pkt[pos + k];
      pos += n;
      packet_beats_due.push_back(clrfs_pkg::out_t'{out_word: w, out_bytes: 4'(n),
                                                   out_last: pos >= len});
      released++;
    end
  endtask

  // datagram reassembly for one accepted input beat
  task automatic accept_datagram_beat(input clrfs_pkg::in_t beat, output int released);
    int unsigned take, k;
    take = (beat.in_bytes > 4'd8) ? 8 : beat.in_bytes;
    released = 0;
    for (k = 0; k < take; k++) begin
      if (rx_len < clrfs_pkg::FRAME_BYTES) rx_bytes[rx_len] = beat.in_word[63 - 8*k -: 8];
      if (rx_len < clrfs_pkg::LEN_MAX) rx_len++;
    end
    if (beat.in_last) begin
      if (rx_len == clrfs_pkg::FRAME_BYTES) build_packet(released);
      rx_len = 0;
    end
  endtask

  // offer one beat, entered and left at a falling edge
  task automatic push_beat(input clrfs_pkg::in_t beat, output int released);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accept_datagram_beat(beat, released);
    beats_pushed++;
    @(negedge clk);
  endtask

  // split a datagram into beats, optionally with uneven byte counts
  task automatic send_bytes(input logic [7:0] data [$], input bit ragged);
    int unsigned total, pos, rem, eff, k;
    logic [3:0]  cnt;
    logic [63:0] w;
    bit          zero_tail;
    int          released;
    total     = data.size();
    zero_tail = (total == 0) || ($urandom_range(11) == 0);
    pos = 0;
    while (pos < total) begin
      rem = total - pos;
      eff = (rem < 8) ? rem : 8;
      if (ragged && $urandom_range(1) == 0) eff = $urandom_range(eff);
      // counts above eight behave as eight
      cnt = (eff == 8 && $urandom_range(3) == 0) ? 4'($urandom_range(15, 9)) : 4'(eff);
      w = {$urandom, $urandom};
      for (k = 0; k < eff; k++) w[63 - 8*k -: 8] = data[pos + k];
      pos += eff;
      push_beat(clrfs_pkg::in_t'{in_word: w, in_bytes: cnt,
                                 in_last: (pos >= total) && !zero_tail}, released);
    end
    if (zero_tail)
      push_beat(clrfs_pkg::in_t'{in_word: {$urandom, $urandom}, in_bytes: 4'd0,
                                 in_last: 1'b1}, released);
  endtask

  // well-formed frame with a random payload
  task automatic send_frame();
    logic [7:0]  data [$];
    logic [31:0] seq;
    case ($urandom_range(15))
      0:       seq = $urandom;
      1:       seq = $urandom_range(3);
      2:       seq = 32'hFFFF_FFFF;
      default: seq = next_seq;
    endcase
    next_seq = seq + 1;
    data.push_back(seq[31:24]);
    data.push_back(seq[23:16]);
    data.push_back(seq[15:8]);
    data.push_back(seq[7:0]);
    repeat (PAYLOAD_LEN) data.push_back(8'($urandom));
    send_bytes(data, $urandom_range(3) == 0);
  endtask

  // datagram of the wrong length, dropped by the block
  task automatic send_junk(input int unsigned len);
    logic [7:0] data [$];
    repeat (len) data.push_back(8'($urandom));
    send_bytes(data, $urandom_range(1) == 1);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      clrfs_pkg::CFG_CREDIT_PER_FRAME:    cfg_cpf  = val;
      clrfs_pkg::CFG_CREDIT_CAP:          cfg_cap  = val;
      clrfs_pkg::CFG_REDUNDANCY_DISTANCE: cfg_dist = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // let every expected beat out, then give the ring writes time to finish
  task automatic wait_until_drained();
    while (packet_beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    int          r, ph, released;
    int unsigned mark;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed beats
    for (r = 0; r < PROBE_ROWS; r++) begin
      push_beat(clrfs_pkg::in_t'{in_word: PROBES[r].word, in_bytes: PROBES[r].cnt,
                                 in_last: PROBES[r].last}, released);
      if (released != PROBES[r].want) begin
        $display("%0t: row %0d expected %0d packet beats, got %0d", $time, r,
                 PROBES[r].want, released);
        errors++;
      end
    end

    // random phases, each with its own settings and idling
    for (ph = 0; ph < 5; ph++) begin
      in_valid <= 1'b0;
      wait_until_drained();
      case (ph)
        0: begin
          write_reg(clrfs_pkg::CFG_CREDIT_PER_FRAME, 16'hFFFF);
          write_reg(clrfs_pkg::CFG_CREDIT_CAP, 16'hFFFF);
          write_reg(clrfs_pkg::CFG_REDUNDANCY_DISTANCE, {8'($urandom), 8'hFF});
          next_seq      = 32'd254;
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          write_reg(clrfs_pkg::CFG_CREDIT_PER_FRAME, 16'h0000);
          write_reg(clrfs_pkg::CFG_CREDIT_CAP, 16'h0000);
          write_reg(clrfs_pkg::CFG_REDUNDANCY_DISTANCE, {8'($urandom), 8'h01});
          in_idle_pct   = 64;
          out_stall_pct = 0;
        end
        2: begin
          write_reg(clrfs_pkg::CFG_CREDIT_PER_FRAME, 16'd400);
          write_reg(clrfs_pkg::CFG_CREDIT_CAP, 16'd700);
          write_reg(clrfs_pkg::CFG_REDUNDANCY_DISTANCE, {8'($urandom), 8'h00});
          write_reg(CFG_INDEX_SPARE, 16'($urandom));
          in_idle_pct   = 0;
          out_stall_pct = 64;
        end
        3: begin
          write_reg(clrfs_pkg::CFG_CREDIT_PER_FRAME, 16'd162);
          write_reg(clrfs_pkg::CFG_CREDIT_CAP, 16'hFFFF);
          write_reg(clrfs_pkg::CFG_REDUNDANCY_DISTANCE, 16'($urandom_range(20, 1)));
          in_idle_pct   = 27;
          out_stall_pct = 27;
        end
        default: begin
          write_reg(clrfs_pkg::CFG_CREDIT_PER_FRAME, 16'd1000);
          write_reg(clrfs_pkg::CFG_CREDIT_CAP, 16'd2000);
          write_reg(clrfs_pkg::CFG_REDUNDANCY_DISTANCE, 16'($urandom_range(40, 1)));
          in_idle_pct   = 0;
          out_stall_pct = 0;
          // receiver holds off so the block backs up onto its input
          hold_left     = HOLD_CYCLES;
        end
      endcase
      mark = beats_pushed;
      while (beats_pushed - mark < BEATS_PER_PHASE) begin
        case ($urandom_range(9))
          0:       send_junk($urandom_range(8));
          1:       send_junk($urandom_range(clrfs_pkg::FRAME_BYTES - 1, 9));
          2:       send_junk($urandom_range(clrfs_pkg::FRAME_BYTES + 60,
                                            clrfs_pkg::FRAME_BYTES + 1));
          default: send_frame();
        endcase
      end
    end

    in_valid <= 1'b0;
    wait_until_drained();
    if (errors == 0)
      $display("credit_limited_redundant_frame_sender: match");
    else
      $display("credit_limited_redundant_frame_sender: mismatch");
    $finish;
  end

  // receiver readiness, with the long hold-off counted here
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // compare each output beat with the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (packet_beats_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h/%0d/%b", $time,
                 out_data.out_word, out_data.out_bytes, out_data.out_last);
        errors++;
      end else begin
        due_beat = packet_beats_due.pop_front();
        if (out_data.out_word !== due_beat.out_word) begin
          $display("%0t: out_word expected %h, got %h", $time, due_beat.out_word,
                   out_data.out_word);
          errors++;
        end
        if (out_data.out_bytes !== due_beat.out_bytes) begin
          $display("%0t: out_bytes expected %0d, got %0d", $time, due_beat.out_bytes,
                   out_data.out_bytes);
          errors++;
        end
        if (out_data.out_last !== due_beat.out_last) begin
          $display("%0t: out_last expected %b, got %b", $time, due_beat.out_last,
                   out_data.out_last);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles == RUN_LIMIT) begin
      $display("credit_limited_redundant_frame_sender: mismatch");
      $finish;
    end
  end

endmodule
